/* hdl/sat_pkg.sv */
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants of the separating axis polygon overlap test.
// ----------------------------------------------------------------------------
package sat_pkg;

	// width of the coordinate fields on the vertex channel
	localparam int COORD_IN_W = 16;
	// a polygon needs this many vertices before it has an edge
	localparam int MIN_VERTS  = 2;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_FEW = 2'd1,
		ST_OVF = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE_A,
		S_EDGE_B,
		S_DRAIN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rot;
	} cell_ctrl_t;

endpackage

/* hdl/sat_in_if.sv */
// ----------------------------------------------------------------------------
// sat_in_if
// Vertex channel: one polygon vertex per beat, tagged with its polygon.
// ----------------------------------------------------------------------------
interface sat_in_if;
	import sat_pkg::*;

	logic                         valid;
	logic                         ready;
	logic                         poly_sel;
	logic signed [COORD_IN_W-1:0] vx;
	logic signed [COORD_IN_W-1:0] vy;
	logic                         last;

	modport source (output valid, poly_sel, vx, vy, last, input ready);
	modport sink   (input valid, poly_sel, vx, vy, last, output ready);

endinterface

/* hdl/sat_out_if.sv */
// ----------------------------------------------------------------------------
// sat_out_if
// Result channel: one beat per tested polygon pair.
// ----------------------------------------------------------------------------
interface sat_out_if;

	logic       valid;
	logic       ready;
	logic       collide;
	logic [1:0] status;

	modport source (output valid, collide, status, input ready);
	modport sink   (input valid, collide, status, output ready);

endinterface

/* hdl/sat_convex_polygon_overlap_top.sv */
// ----------------------------------------------------------------------------
// sat_convex_polygon_overlap_top
// Separating axis overlap test of two convex polygons.
//
// Vertices arrive one per beat on vtx, tagged for polygon A or B, and shift
// into a row of MAX_VERTS cells per polygon; a vertex beyond a full row is
// dropped and flags overflow. The beat marked last stores its vertex and
// starts the test, and vtx stays stalled until the result is placed on res.
// During the test the cells of A, then of B, rotate one position per cycle,
// so the first two cells present one edge per cycle; its perpendicular is
// broadcast to every cell, all cells project in parallel and a registered
// min/max tree of clog2(MAX_VERTS) levels reduces each polygon to an
// interval. A test issues the nA + nB edges, drains the axis pipeline and
// the trees, and then places its result in S_DONE. A pair with an overflow
// or with a polygon under two vertices skips the edge issue and goes
// straight to S_DONE. Coordinates are taken from the low min(COORD_BITS,
// 16) bits. Intervals that only touch count as overlap.
// ----------------------------------------------------------------------------
module sat_convex_polygon_overlap_top #(
	parameter int MAX_VERTS  = 16,
	parameter int COORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sat_in_if.sink    vtx,
	sat_out_if.source res
);
	import sat_pkg::*;

	localparam int CW    = (COORD_BITS < COORD_IN_W) ? COORD_BITS : COORD_IN_W;
	localparam int AW    = CW + 1;
	localparam int DW    = 2 * CW + 2;
	localparam int CNT_W = $clog2(MAX_VERTS + 1);

	state_t               state_q;
	state_t               state_d;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     idx_d;
	logic [CNT_W-1:0]     cnt_q [2];
	logic [CNT_W-1:0]     cnt_n [2];
	logic                 ovf_q;
	logic                 ovf_n;
	logic [1:0]           full;
	status_t              status_n;
	status_t              status_q;
	logic                 sep_q;
	logic                 vtx_acc;
	logic                 issue;
	logic                 src;
	logic                 finish;
	logic                 busy;
	logic                 gap;

	cell_ctrl_t           ctrl [2];
	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic signed [CW-1:0] c_x [2][MAX_VERTS];
	logic signed [CW-1:0] c_y [2][MAX_VERTS];
	logic signed [DW-1:0] c_d [2][MAX_VERTS];
	logic [MAX_VERTS-1:0] act [2];

	logic signed [AW-1:0] ex;
	logic signed [AW-1:0] ey;
	logic signed [AW-1:0] ax_s1;
	logic signed [AW-1:0] ay_s1;
	logic                 axis_v_s1;
	logic                 dot_v_s2;

	logic [1:0]           tr_ov;
	logic [1:0]           tr_busy;
	logic signed [DW-1:0] tr_mn [2];
	logic signed [DW-1:0] tr_mx [2];

	logic                 res_valid_q;
	logic                 res_collide_q;
	logic [1:0]           res_status_q;

	assign vtx.ready = (state_q == S_IDLE);
	assign vtx_acc   = vtx.valid && vtx.ready;
	assign in_x      = vtx.vx[CW-1:0];
	assign in_y      = vtx.vy[CW-1:0];

	// counts and status as they stand once the current beat is stored
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			full[p]        = (cnt_q[p] == CNT_W'(MAX_VERTS));
			ctrl[p].load   = vtx_acc && (vtx.poly_sel == 1'(p)) && !full[p];
			ctrl[p].rot    = issue && (src == 1'(p));
			cnt_n[p]       = cnt_q[p] + CNT_W'(ctrl[p].load);
		end
		ovf_n = ovf_q | (vtx_acc && full[vtx.poly_sel]);
		if (ovf_n) begin
			status_n = ST_OVF;
		end else if (cnt_n[0] < CNT_W'(MIN_VERTS) || cnt_n[1] < CNT_W'(MIN_VERTS)) begin
			status_n = ST_FEW;
		end else begin
			status_n = ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		issue   = 1'b0;
		src     = 1'b0;
		finish  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (vtx_acc && vtx.last) begin
					idx_d   = '0;
					state_d = (status_n == ST_OK) ? S_EDGE_A : S_DONE;
				end
			end
			S_EDGE_A: begin
				issue = 1'b1;
				src   = 1'b0;
				if (idx_q == CNT_W'(cnt_q[0] - 1'b1)) begin
					idx_d   = '0;
					state_d = S_EDGE_B;
				end else begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
			end
			S_EDGE_B: begin
				issue = 1'b1;
				src   = 1'b1;
				if (idx_q == CNT_W'(cnt_q[1] - 1'b1)) begin
					idx_d   = '0;
					state_d = S_DRAIN;
				end else begin
					idx_d = CNT_W'(idx_q + 1'b1);
				end
			end
			S_DRAIN: begin
				if (!busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!res_valid_q || res.ready) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cell rows: shift in at cell 0, rotate within the first cnt cells
	for (genvar p = 0; p < 2; p++) begin : g_poly
		for (genvar i = 0; i < MAX_VERTS; i++) begin : g_cell
			logic signed [CW-1:0] lx;
			logic signed [CW-1:0] ly;
			logic signed [CW-1:0] rx;
			logic signed [CW-1:0] ry;

			if (i == 0) begin : g_head
				assign lx = in_x;
				assign ly = in_y;
			end else begin : g_body
				assign lx = c_x[p][i-1];
				assign ly = c_y[p][i-1];
			end

			if (i == MAX_VERTS - 1) begin : g_tail
				assign rx = c_x[p][0];
				assign ry = c_y[p][0];
			end else begin : g_mid
				assign rx = (cnt_q[p] == CNT_W'(i + 1)) ? c_x[p][0] : c_x[p][i+1];
				assign ry = (cnt_q[p] == CNT_W'(i + 1)) ? c_y[p][0] : c_y[p][i+1];
			end

			assign act[p][i] = (CNT_W'(i) < cnt_q[p]);

			sat_cell #(
				.CW (CW)
			) u_cell (
				.clk   (clk),
				.ctrl  (ctrl[p]),
				.ld_x  (lx),
				.ld_y  (ly),
				.rot_x (rx),
				.rot_y (ry),
				.ax    (ax_s1),
				.ay    (ay_s1),
				.x     (c_x[p][i]),
				.y     (c_y[p][i]),
				.d     (c_d[p][i])
			);
		end

		sat_minmax_tree #(
			.N (MAX_VERTS),
			.W (DW)
		) u_tree (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dot_v_s2),
			.d         (c_d[p]),
			.act       (act[p]),
			.out_valid (tr_ov[p]),
			.mn        (tr_mn[p]),
			.mx        (tr_mx[p]),
			.busy      (tr_busy[p])
		);
	end

	// current edge sits in cells 0 and 1 of the rotating row
	assign ex = AW'(c_x[src][1]) - AW'(c_x[src][0]);
	assign ey = AW'(c_y[src][1]) - AW'(c_y[src][0]);

	always_ff @(posedge clk) begin
		ax_s1 <= -ey;
		ay_s1 <= ex;
	end

	assign busy = axis_v_s1 | dot_v_s2 | (|tr_busy);
	assign gap  = (tr_mx[0] < tr_mn[1]) || (tr_mx[1] < tr_mn[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q[0]    <= '0;
			cnt_q[1]    <= '0;
			ovf_q       <= 1'b0;
			status_q    <= ST_OK;
			sep_q       <= 1'b0;
			axis_v_s1   <= 1'b0;
			dot_v_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			axis_v_s1 <= issue;
			dot_v_s2  <= axis_v_s1;
			if (vtx_acc) begin
				cnt_q[0] <= cnt_n[0];
				cnt_q[1] <= cnt_n[1];
				ovf_q    <= ovf_n;
				if (vtx.last) begin
					status_q <= status_n;
				end
			end
			if (vtx_acc && vtx.last) begin
				sep_q <= 1'b0;
			end else if (tr_ov[0] && gap) begin
				sep_q <= 1'b1;
			end
			if (finish) begin
				cnt_q[0]    <= '0;
				cnt_q[1]    <= '0;
				ovf_q       <= 1'b0;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			res_collide_q <= (status_q == ST_OK) && !sep_q;
			res_status_q  <= status_q;
		end
	end

	assign res.valid   = res_valid_q;
	assign res.collide = res_collide_q;
	assign res.status  = res_status_q;

	// the verdict is only taken once every axis has left the pipeline
	a_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |-> !busy)
		else $error("result taken while axes still in flight");

	a_tree_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		tr_ov[0] |-> (state_q == S_EDGE_A || state_q == S_EDGE_B || state_q == S_DRAIN))
		else $error("interval beat outside a running test");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_acc && vtx.last |=> state_q != S_IDLE)
		else $error("last vertex beat did not start a test");

	a_edge_count: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> cnt_q[src] >= CNT_W'(MIN_VERTS))
		else $error("edge issued from a polygon without an edge");

endmodule

/* hdl/sat_cell.sv */
// ----------------------------------------------------------------------------
// sat_cell
// One vertex cell: holds a vertex, shifts it in from the left neighbor while
// loading, takes it from the right neighbor while the edges rotate, and
// projects it onto the broadcast axis every cycle.
// ----------------------------------------------------------------------------
module sat_cell #(
	parameter int CW = 16
) (
	input  logic                      clk,
	input  sat_pkg::cell_ctrl_t       ctrl,
	input  logic signed [CW-1:0]      ld_x,
	input  logic signed [CW-1:0]      ld_y,
	input  logic signed [CW-1:0]      rot_x,
	input  logic signed [CW-1:0]      rot_y,
	input  logic signed [CW:0]        ax,
	input  logic signed [CW:0]        ay,
	output logic signed [CW-1:0]      x,
	output logic signed [CW-1:0]      y,
	output logic signed [2*CW+1:0]    d
);
	import sat_pkg::*;

	localparam int DW = 2 * CW + 2;

	logic signed [CW-1:0] x_q;
	logic signed [CW-1:0] y_q;
	logic signed [2*CW:0] px;
	logic signed [2*CW:0] py;
	logic signed [DW-1:0] d_s2;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			x_q <= ld_x;
			y_q <= ld_y;
		end else if (ctrl.rot) begin
			x_q <= rot_x;
			y_q <= rot_y;
		end
	end

	assign px = x_q * ax;
	assign py = y_q * ay;

	always_ff @(posedge clk) begin
		d_s2 <= DW'(px) + DW'(py);
	end

	assign x = x_q;
	assign y = y_q;
	assign d = d_s2;

endmodule

/* hdl/sat_minmax_tree.sv */
// ----------------------------------------------------------------------------
// sat_minmax_tree
// Registered pairwise tree that reduces the active cell projections of one
// polygon to their minimum and maximum, one level per cycle.
// ----------------------------------------------------------------------------
module sat_minmax_tree #(
	parameter int N = 16,
	parameter int W = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic signed [W-1:0] d [N],
	input  logic [N-1:0]        act,
	output logic                out_valid,
	output logic signed [W-1:0] mn,
	output logic signed [W-1:0] mx,
	output logic                busy
);
	localparam int L = $clog2(N);
	localparam int P = 1 << L;

	// internal nodes in heap order, leaves follow them in the flat view
	logic signed [W-1:0] nd_mn_q [P-1];
	logic signed [W-1:0] nd_mx_q [P-1];
	logic [P-2:0]        nd_v_q;
	logic signed [W-1:0] nd_mn_d [P-1];
	logic signed [W-1:0] nd_mx_d [P-1];
	logic [P-2:0]        nd_v_d;
	logic signed [W-1:0] t_mn [2*P-1];
	logic signed [W-1:0] t_mx [2*P-1];
	logic [2*P-2:0]      t_v;
	logic [L-1:0]        vpipe_q;

	always_comb begin
		int l;
		int r;
		for (int k = 0; k < 2 * P - 1; k++) begin
			if (k < P - 1) begin
				t_mn[k] = nd_mn_q[k];
				t_mx[k] = nd_mx_q[k];
				t_v[k]  = nd_v_q[k];
			end else if (k - (P - 1) < N) begin
				t_mn[k] = d[k-(P-1)];
				t_mx[k] = d[k-(P-1)];
				t_v[k]  = act[k-(P-1)];
			end else begin
				t_mn[k] = '0;
				t_mx[k] = '0;
				t_v[k]  = 1'b0;
			end
		end
		for (int n = 0; n < P - 1; n++) begin
			l = 2 * n + 1;
			r = 2 * n + 2;
			nd_v_d[n] = t_v[l] | t_v[r];
			if (!t_v[r]) begin
				nd_mn_d[n] = t_mn[l];
				nd_mx_d[n] = t_mx[l];
			end else if (!t_v[l]) begin
				nd_mn_d[n] = t_mn[r];
				nd_mx_d[n] = t_mx[r];
			end else begin
				nd_mn_d[n] = (t_mn[l] < t_mn[r]) ? t_mn[l] : t_mn[r];
				nd_mx_d[n] = (t_mx[l] > t_mx[r]) ? t_mx[l] : t_mx[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		nd_mn_q <= nd_mn_d;
		nd_mx_q <= nd_mx_d;
		nd_v_q  <= nd_v_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpipe_q <= '0;
		end else begin
			vpipe_q <= {vpipe_q[L-2:0], in_valid};
		end
	end

	assign out_valid = vpipe_q[L-1];
	assign busy      = |vpipe_q;
	assign mn        = nd_mn_q[0];
	assign mx        = nd_mx_q[0];

endmodule

/* tb/sat_convex_polygon_overlap_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_convex_polygon_overlap_top_tb
// Self-checking bench for the separating axis polygon overlap test.
//
// A short table of hand-picked pairs comes first: a lone vertex, an
// overflowing store, full-range crossing diagonals, and a polygon that
// collapses to a point. It is followed by random pairs, most of them convex
// polygons around random centers, some scattered points, some too short and
// some too long. Every accepted vertex beat feeds an independent
// predictor, and each result beat is checked field by field against the
// oldest expected verdict. Both channels idle at random, and the receiver
// holds off for long stretches so that the block backs up onto its input.
// ----------------------------------------------------------------------------
module sat_convex_polygon_overlap_top_tb;
	import sat_pkg::*;

	localparam int MAX_VERTS    = 16;
	localparam int COORD_BITS   = 16;
	localparam int RAND_BEATS   = 500;
	localparam int GAP_PCT      = 13;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 2 * MAX_VERTS + $clog2(MAX_VERTS) + 16;
	// beat counts that bound the stretch without idling
	localparam int QUIET_LO     = 250;
	localparam int QUIET_HI     = 340;
	// beat counts at which the receiver starts a long hold-off
	localparam int PRESS_1      = 90;
	localparam int PRESS_2      = 420;
	localparam longint C_MAX    = (longint'(1) <<< (COORD_IN_W - 1)) - 1;
	localparam longint C_MIN    = -C_MAX - 1;

	typedef logic signed [COORD_IN_W-1:0] coord_t;
	typedef enum bit {
		POLY_A = 1'b0,
		POLY_B = 1'b1
	} poly_t;

	typedef struct {
		poly_t  sel;
		coord_t x;
		coord_t y;
		bit     last;
	} vertex_beat_t;

	typedef struct {
		bit      collide;
		status_t status;
	} verdict_t;

	typedef struct {
		vertex_beat_t beat;
		bit           typed;
		verdict_t     want;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sat_in_if  vtx ();
	sat_out_if res ();

	sat_convex_polygon_overlap_top #(
		.MAX_VERTS (MAX_VERTS),
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.vtx   (vtx),
		.res   (res)
	);

	always #10 clk = ~clk;

	// predictor copy of the vertex stores
	coord_t      store_x [2][MAX_VERTS];
	coord_t      store_y [2][MAX_VERTS];
	int unsigned store_n [2];
	bit          store_ovf;

	verdict_t     verdict_q [$];
	dir_row_t     dir_rows [$];
	vertex_beat_t pair_beats [$];
	verdict_t     oldest;

	int  errors       = 0;
	int  beats_in     = 0;
	int  results_seen = 0;
	int  n_overlap    = 0;
	int  n_few        = 0;
	int  n_ovf        = 0;
	int  holds_done   = 0;
	bit  gaps_on      = 1'b1;
	bit  pressure_req = 1'b0;

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10) begin
			$display("[%0t] %s", $time, msg);
		end
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > C_MAX) begin
			return coord_t'(C_MAX);
		end
		if (v < C_MIN) begin
			return coord_t'(C_MIN);
		end
		return coord_t'(v);
	endfunction

	function automatic void span_on_axis(int p, longint ax, longint ay,
			output longint lo, output longint hi);
		longint d;
		for (int unsigned i = 0; i < store_n[p]; i++) begin
			d = longint'(store_x[p][i]) * ax + longint'(store_y[p][i]) * ay;
			if (i == 0 || d < lo) begin
				lo = d;
			end
			if (i == 0 || d > hi) begin
				hi = d;
			end
		end
	endfunction

	// true when some edge normal of polygon src leaves a strict gap
	function automatic bit edge_of_splits(int src);
		int unsigned j;
		longint      ex, ey, a_lo, a_hi, b_lo, b_hi;
		for (int unsigned i = 0; i < store_n[src]; i++) begin
			j  = (i + 1 < store_n[src]) ? i + 1 : 0;
			ex = longint'(store_x[src][j]) - longint'(store_x[src][i]);
			ey = longint'(store_y[src][j]) - longint'(store_y[src][i]);
			span_on_axis(POLY_A, -ey, ex, a_lo, a_hi);
			span_on_axis(POLY_B, -ey, ex, b_lo, b_hi);
			if (a_hi < b_lo || b_hi < a_lo) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// stores one vertex; on the closing beat returns 1 with the verdict
	function automatic bit overlap_after_beat(vertex_beat_t b, output verdict_t v);
		int p;
		p = b.sel;
		if (store_n[p] < MAX_VERTS) begin
			store_x[p][store_n[p]] = b.x;
			store_y[p][store_n[p]] = b.y;
			store_n[p]++;
		end else begin
			store_ovf = 1'b1;
		end
		if (!b.last) begin
			return 1'b0;
		end
		v.collide = 1'b0;
		if (store_ovf) begin
			v.status = ST_OVF;
		end else if (store_n[POLY_A] < MIN_VERTS || store_n[POLY_B] < MIN_VERTS) begin
			v.status = ST_FEW;
		end else begin
			v.status  = ST_OK;
			v.collide = !edge_of_splits(POLY_A) && !edge_of_splits(POLY_B);
		end
		store_n[POLY_A] = 0;
		store_n[POLY_B] = 0;
		store_ovf       = 1'b0;
		return 1'b1;
	endfunction

	function automatic void add_row(poly_t sel, int x, int y, bit last,
			bit typed = 1'b0, bit collide = 1'b0, status_t st = ST_OK);
		dir_row_t r;
		r.beat.sel        = sel;
		r.beat.x          = coord_t'(x);
		r.beat.y          = coord_t'(y);
		r.beat.last       = last;
		r.typed           = typed;
		r.want.collide    = collide;
		r.want.status     = st;
		dir_rows.push_back(r);
	endfunction

	function automatic void fill_directed();
		// a lone vertex is no polygon
		add_row(POLY_A, -32768, 32767, 1'b1, 1'b1, 1'b0, ST_FEW);
		// one vertex too many for A; overflow outranks the short B
		for (int i = 0; i < MAX_VERTS + 1; i++) begin
			add_row(POLY_A, (i % 2) ? 32767 : -32768, (i % 3 == 0) ? -32768 : 32767, 1'b0);
		end
		add_row(POLY_B, 0, 0, 1'b1, 1'b1, 1'b0, ST_OVF);
		// full-range diagonals crossing at the origin
		add_row(POLY_A, -32768, -32768, 1'b0);
		add_row(POLY_A, 32767, 32767, 1'b0);
		add_row(POLY_B, 32767, -32768, 1'b0);
		add_row(POLY_B, -32768, 32767, 1'b1);
		// A is one point twice, so its edges have no length; B just touches it
		add_row(POLY_A, 5, 5, 1'b0);
		add_row(POLY_A, 5, 5, 1'b0);
		add_row(POLY_B, 5, 5, 1'b0);
		add_row(POLY_B, 9, 5, 1'b1);
	endfunction

	// one random pair of polygons into pair_beats
	task automatic build_pair();
		int           kind;
		bit           big;
		bit           blocked;
		int           cnt [2];
		int           used [2];
		int           cx, cy, r;
		real          ang, step;
		coord_t       gx [2][MAX_VERTS+2];
		coord_t       gy [2][MAX_VERTS+2];
		vertex_beat_t b;
		poly_t        p;

		kind = $urandom_range(99, 0);
		big  = ($urandom_range(3, 0) == 0);
		for (int s = 0; s < 2; s++) begin
			if (kind < 85) begin
				cnt[s] = ($urandom_range(19, 0) == 0) ? $urandom_range(MAX_VERTS, 7)
					: $urandom_range(6, 2);
			end else if (kind < 92) begin
				cnt[s] = $urandom_range(4, 0);
			end else begin
				cnt[s] = $urandom_range(5, 1);
			end
		end
		if (kind >= 92) begin
			cnt[$urandom_range(1, 0)] = $urandom_range(MAX_VERTS + 2, MAX_VERTS + 1);
		end else if (kind >= 85) begin
			cnt[$urandom_range(1, 0)] = $urandom_range(1, 0);
		end
		if (cnt[0] + cnt[1] == 0) begin
			cnt[0] = 1;
		end

		for (int s = 0; s < 2; s++) begin
			if (kind >= 70 && kind < 85) begin
				// scattered points over the whole range
				for (int k = 0; k < cnt[s]; k++) begin
					gx[s][k] = coord_t'($urandom);
					gy[s][k] = coord_t'($urandom);
				end
			end else begin
				// points on a circle with increasing angle stay convex
				r    = big ? $urandom_range(20000, 100) : $urandom_range(400, 1);
				cx   = big ? int'($urandom_range(24000, 0)) - 12000
					: int'($urandom_range(1200, 0)) - 600;
				cy   = big ? int'($urandom_range(24000, 0)) - 12000
					: int'($urandom_range(1200, 0)) - 600;
				ang  = $urandom_range(359, 0) * 3.14159265 / 180.0;
				step = 6.28318530 / ((cnt[s] > 0) ? cnt[s] : 1);
				for (int k = 0; k < cnt[s]; k++) begin
					gx[s][k] = clamp_coord(longint'(cx + $rtoi(r * $cos(ang))));
					gy[s][k] = clamp_coord(longint'(cy + $rtoi(r * $sin(ang))));
					ang = ang + step * (0.5 + $urandom_range(50, 0) / 100.0);
				end
			end
		end

		pair_beats.delete();
		used    = '{0, 0};
		blocked = ($urandom_range(2, 0) == 0);
		while (used[0] + used[1] < cnt[0] + cnt[1]) begin
			if (used[0] == cnt[0]) begin
				p = POLY_B;
			end else if (used[1] == cnt[1]) begin
				p = POLY_A;
			end else if (blocked) begin
				p = POLY_A;
			end else begin
				p = poly_t'($urandom_range(1, 0));
			end
			b.sel  = p;
			b.x    = gx[p][used[p]];
			b.y    = gy[p][used[p]];
			used[p]++;
			b.last = (used[0] + used[1] == cnt[0] + cnt[1]);
			pair_beats.push_back(b);
		end
	endtask

	// starts and ends at a falling edge
	task automatic send_beat(vertex_beat_t b, bit typed, verdict_t want);
		verdict_t v;
		while (gaps_on && $urandom_range(99, 0) < GAP_PCT) begin
			vtx.valid <= 1'b0;
			@(negedge clk);
		end
		vtx.valid    <= 1'b1;
		vtx.poly_sel <= b.sel;
		vtx.vx       <= b.x;
		vtx.vy       <= b.y;
		vtx.last     <= b.last;
		@(posedge clk);
		while (!vtx.ready) begin
			@(posedge clk);
		end
		if (overlap_after_beat(b, v)) begin
			if (typed) begin
				verdict_q.push_back(want);
			end else begin
				verdict_q.push_back(v);
			end
		end
		beats_in++;
		gaps_on = !(beats_in >= QUIET_LO && beats_in < QUIET_HI);
		if (beats_in == PRESS_1 || beats_in == PRESS_2) begin
			pressure_req = 1'b1;
		end
		@(negedge clk);
	endtask

	initial begin
		verdict_t no_claim;
		no_claim.collide = 1'b0;
		no_claim.status  = ST_OK;
		vtx.valid    <= 1'b0;
		vtx.poly_sel <= 1'b0;
		vtx.vx       <= '0;
		vtx.vy       <= '0;
		vtx.last     <= 1'b0;
		res.ready    <= 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		fill_directed();
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
		end
		while (beats_in < dir_rows.size() + RAND_BEATS) begin
			build_pair();
			foreach (pair_beats[i]) begin
				send_beat(pair_beats[i], 1'b0, no_claim);
			end
		end
		vtx.valid <= 1'b0;

		while (verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d vertex beats, %0d results: %0d overlaps, %0d short, %0d overflow",
			beats_in, results_seen, n_overlap, n_few, n_ovf);
		$display("receiver hold-offs: %0d, mismatches: %0d", holds_done, errors);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// result side: random stalls plus long hold-offs on request
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (pressure_req) begin
				pressure_req = 1'b0;
				hold         = HOLD_CYCLES;
				holds_done++;
			end
			if (hold > 0) begin
				hold--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= !(gaps_on && $urandom_range(99, 0) < GAP_PCT);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (verdict_q.size() == 0) begin
				flag_error($sformatf("result beat with nothing expected: collide %0b status %0d",
					res.collide, res.status));
			end else begin
				oldest = verdict_q.pop_front();
				if (res.collide !== oldest.collide) begin
					flag_error($sformatf("collide mismatch: expected %0b, got %0b",
						oldest.collide, res.collide));
				end
				if (res.status !== oldest.status) begin
					flag_error($sformatf("status mismatch: expected %0d, got %0d",
						oldest.status, res.status));
				end
				if (oldest.collide) begin
					n_overlap++;
				end
				if (oldest.status == ST_FEW) begin
					n_few++;
				end
				if (oldest.status == ST_OVF) begin
					n_ovf++;
				end
			end
		end
	end

	// watchdog on cycles without any beat
	initial begin
		int unsigned stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
				stall = 0;
			end else begin
				stall++;
			end
		end
		$display("timeout: no beat on either channel for %0d cycles", STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
